// ===== sv/vrid_pkg.sv =====
// Shared constants, types and helpers of the variable-rate interpolating delay.
`default_nettype none

package vrid_pkg;

    // Line geometry and fixed-point formats
    localparam int DEPTH     = 4096;
    localparam int ADDR_W    = $clog2(DEPTH);
    localparam int LEN_W     = ADDR_W + 1;
    localparam int FRAC_BITS = 16;
    localparam int POS_W     = ADDR_W + FRAC_BITS;
    localparam int RATE_W    = FRAC_BITS + 3;
    localparam int SAMPLE_W  = 24;
    localparam int DIFF_W    = SAMPLE_W + 1;
    localparam int CFG_W     = RATE_W;
    localparam int CFG_IDX_W = 1;

    // Multiplier: unsigned operand up to 5.0 in Q.FRAC_BITS, zero-extended to signed
    localparam int MULA_W    = FRAC_BITS + 4;
    localparam int PROD_W    = MULA_W + DIFF_W;

    // Divider: magnitude of 2*prod + rate over 2*rate
    localparam int DIVN_W    = PROD_W + 1;
    localparam int DIVD_W    = RATE_W + 1;
    localparam int DIVC_W    = $clog2(DIVN_W + 1);

    // Wide signed sum ahead of saturation
    localparam int SUM_W     = DIVN_W + 2;

    // Slots written per item (at most five)
    localparam int SLOT_CNT_W = 3;

    localparam logic [RATE_W-1:0] RATE_ONE = RATE_W'(1) << FRAC_BITS;
    localparam logic [RATE_W-1:0] RATE_MAX = RATE_W'(4) << FRAC_BITS;

    localparam logic signed [SUM_W-1:0] SAT_MAX = SUM_W'(8388607);
    localparam logic signed [SUM_W-1:0] SAT_MIN = -SUM_W'(8388608);

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RATE   = 1'b0,
        REG_LENGTH = 1'b1
    } cfg_reg_t;

    // Sequencer states
    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RD_A,
        ST_RD_B,
        ST_RD_DIFF,
        ST_RD_MUL,
        ST_RD_SUM,
        ST_WR_A,
        ST_WR_B,
        ST_WR_DIFF,
        ST_WR_MUL,
        ST_WR_Y0,
        ST_WR_SETUP,
        ST_WR_TMUL,
        ST_WR_DIVGO,
        ST_WR_DIV,
        ST_WR_STORE,
        ST_DONE
    } state_t;

    // Line memory access
    typedef struct packed {
        logic                       we;
        logic [ADDR_W-1:0]          waddr;
        logic signed [SAMPLE_W-1:0] wdata;
        logic [ADDR_W-1:0]          raddr;
    } mem_req_t;

    // Divider request and response
    typedef struct packed {
        logic              start;
        logic [DIVN_W-1:0] dividend;
        logic [DIVD_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [DIVN_W-1:0] quotient;
    } div_rsp_t;

    // Clamp a wide signed value to the 24-bit sample range
    function automatic logic signed [SAMPLE_W-1:0] sat24(input logic signed [SUM_W-1:0] v);
        logic signed [SAMPLE_W-1:0] r;
        begin
            if (v > SAT_MAX)
            begin
                r = SAT_MAX[SAMPLE_W-1:0];
            end
            else if (v < SAT_MIN)
            begin
                r = SAT_MIN[SAMPLE_W-1:0];
            end
            else
            begin
                r = v[SAMPLE_W-1:0];
            end
            return r;
        end
    endfunction

endpackage

`default_nettype wire

// ===== sv/variable_rate_interpolating_delay.sv =====
// Variable-rate interpolating delay line: sequencer, datapath and configuration.
//
// Usage:
//  - Input channel in_valid/in_ready carries sample_in (signed 24-bit); output
//    channel out_valid/out_ready carries sample_out (signed 24-bit, saturated).
//  - Config port: cfg_we, cfg_index (0 rate, 1 line_length), cfg_data. Writes
//    take effect at once; write only while no item is in flight.
//  - Per item: a linear-interpolated read at the read head, then a straight
//    line from the value one rate step behind the write head to the new sample
//    written over 1 to 5 slots, then both heads advance by the rate.
//  - Each slot written (1..5) costs one pass of the shared bit-serial divider
//    (46 steps); the block takes one item at a time and in_ready is low until
//    the item's transfer is loaded.
//  - Output register: a finished result waits there; the next item is already
//    accepted while the receiver stalls, and its own result waits for the slot.
//  - Reset, and every line_length write, run a clearing pass over all 4096
//    line entries during which in_ready stays low.
`default_nettype none

module variable_rate_interpolating_delay (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic signed [vrid_pkg::SAMPLE_W-1:0] sample_in,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic signed [vrid_pkg::SAMPLE_W-1:0]     sample_out,
    input  wire logic                                cfg_we,
    input  wire logic [vrid_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [vrid_pkg::CFG_W-1:0]          cfg_data
);
    import vrid_pkg::*;

    // Next slot index, wrapping at the line length
    function automatic logic [ADDR_W-1:0] wrap_inc(input logic [ADDR_W-1:0] p,
                                                   input logic [LEN_W-1:0]  len);
        logic [LEN_W-1:0] n;
        begin
            n = {1'b0, p} + LEN_W'(1);
            return (n == len) ? '0 : n[ADDR_W-1:0];
        end
    endfunction

    // Head advance modulo span (the largest rate is at most twice the shortest span)
    function automatic logic [POS_W-1:0] advance(input logic [POS_W-1:0]  pos,
                                                 input logic [RATE_W-1:0] r,
                                                 input logic [LEN_W-1:0]  len);
        logic [POS_W:0] s;
        logic [POS_W:0] span;
        begin
            span = {len, {FRAC_BITS{1'b0}}};
            s    = {1'b0, pos} + (POS_W + 1)'(r);
            if (s >= span)
            begin
                s = s - span;
            end
            if (s >= span)
            begin
                s = s - span;
            end
            return s[POS_W-1:0];
        end
    endfunction

    // Control and configuration registers
    state_t                     state_reg;
    state_t                     state_next;
    logic [RATE_W-1:0]          rate_reg;
    logic [LEN_W-1:0]           len_reg;
    logic [POS_W-1:0]           wpos_reg;
    logic [POS_W-1:0]           rpos_reg;
    logic [ADDR_W-1:0]          clr_reg;
    logic                       out_valid_reg;

    // Datapath registers
    logic signed [SAMPLE_W-1:0] sample_reg;
    logic signed [POS_W:0]      x0_reg;
    logic signed [SAMPLE_W-1:0] a_reg;
    logic signed [DIFF_W-1:0]   diff_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [SAMPLE_W-1:0] y0_reg;
    logic signed [SAMPLE_W-1:0] result_reg;
    logic [ADDR_W-1:0]          ptr_reg;
    logic [RATE_W-1:0]          t_reg;
    logic [SLOT_CNT_W-1:0]      cnt_reg;
    logic                       neg_reg;
    logic signed [SAMPLE_W-1:0] out_data_reg;

    // Combinational signals
    logic [RATE_W-1:0]          reff;
    logic                       len_write;
    logic [LEN_W-1:0]           len_clamp;
    logic                       out_load;
    logic signed [POS_W:0]      x0_next;
    logic [FRAC_BITS-1:0]       fr0;
    logic [FRAC_BITS-1:0]       frr;
    logic [ADDR_W-1:0]          ipr;
    logic signed [LEN_W:0]      x0f;
    logic signed [LEN_W:0]      lenx;
    logic signed [LEN_W:0]      m1;
    logic signed [LEN_W:0]      m2;
    logic [ADDR_W-1:0]          slot_a;
    logic signed [LEN_W:0]      cnt_calc;
    logic signed [MULA_W-1:0]   mul_a;
    logic signed [PROD_W-1:0]   mul_p;
    logic [PROD_W-1:0]          rnd_sum;
    logic signed [PROD_W-FRAC_BITS-1:0] rnd;
    logic signed [SAMPLE_W-1:0] interp_sat;
    logic signed [DIVN_W:0]     n_val;
    logic [DIVD_W-1:0]          d_val;
    logic signed [DIVN_W:0]     mag_w;
    logic signed [SUM_W-1:0]    q_signed;
    logic signed [SAMPLE_W-1:0] store_val;
    logic signed [SAMPLE_W-1:0] rdata;
    mem_req_t                   mem_req;
    div_req_t                   div_req;
    div_rsp_t                   div_rsp;

    // Shared units
    vrid_line u_line (
        .clk   (clk),
        .req   (mem_req),
        .rdata (rdata)
    );

    vrid_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Effective rate and configuration decode
    always_comb
    begin
        if (rate_reg == '0)
        begin
            reff = RATE_W'(1);
        end
        else if (rate_reg > RATE_MAX)
        begin
            reff = RATE_MAX;
        end
        else
        begin
            reff = rate_reg;
        end

        if (cfg_data < CFG_W'(2))
        begin
            len_clamp = LEN_W'(2);
        end
        else if (cfg_data > CFG_W'(DEPTH))
        begin
            len_clamp = LEN_W'(DEPTH);
        end
        else
        begin
            len_clamp = cfg_data[LEN_W-1:0];
        end

        len_write = cfg_we && (cfg_index == REG_LENGTH);
        out_load  = (state_reg == ST_DONE) && (!out_valid_reg || out_ready);
    end

    // Head positions and slot arithmetic
    always_comb
    begin
        x0_next  = $signed({1'b0, wpos_reg}) - $signed((POS_W + 1)'(reff));
        fr0      = x0_reg[FRAC_BITS-1:0];
        frr      = rpos_reg[FRAC_BITS-1:0];
        ipr      = rpos_reg[POS_W-1:FRAC_BITS];
        x0f      = (LEN_W + 1)'(x0_reg[POS_W:FRAC_BITS]);
        x0f      = {x0_reg[POS_W], x0_reg[POS_W:FRAC_BITS]};
        lenx     = $signed({1'b0, len_reg});
        m1       = (x0f < 0) ? (x0f + lenx) : x0f;
        m2       = (m1 < 0) ? (m1 + lenx) : m1;
        slot_a   = m2[ADDR_W-1:0];
        cnt_calc = $signed({2'b00, wpos_reg[POS_W-1:FRAC_BITS]}) + (LEN_W + 1)'(1) - x0f;
    end

    // Shared multiplier and rounding of interpolations
    always_comb
    begin
        unique case (state_reg)
            ST_RD_MUL: mul_a = $signed({{(MULA_W - FRAC_BITS){1'b0}}, frr});
            ST_WR_MUL: mul_a = $signed({{(MULA_W - FRAC_BITS){1'b0}}, fr0});
            default:   mul_a = $signed({{(MULA_W - RATE_W){1'b0}}, t_reg});
        endcase
        mul_p      = mul_a * diff_reg;
        rnd_sum    = prod_reg + (PROD_W'(1) << (FRAC_BITS - 1));
        rnd        = rnd_sum[PROD_W-1:FRAC_BITS];
        interp_sat = sat24(SUM_W'(a_reg) + SUM_W'(rnd));
    end

    // Divider operands: floor((2*prod + r) / (2*r)) by magnitude
    always_comb
    begin
        n_val = $signed({prod_reg[PROD_W-1], prod_reg, 1'b0})
              + $signed((DIVN_W + 1)'(reff));
        d_val = {reff, 1'b0};
        if (n_val[DIVN_W])
        begin
            mag_w = -n_val + $signed((DIVN_W + 1)'(d_val)) - (DIVN_W + 1)'(1);
        end
        else
        begin
            mag_w = n_val;
        end
        div_req.start    = (state_reg == ST_WR_DIVGO);
        div_req.dividend = mag_w[DIVN_W-1:0];
        div_req.divisor  = d_val;

        q_signed  = neg_reg ? -$signed({2'b00, div_rsp.quotient})
                            : $signed({2'b00, div_rsp.quotient});
        store_val = sat24(SUM_W'(y0_reg) + q_signed);
    end

    // Memory port control
    always_comb
    begin
        mem_req.we    = 1'b0;
        mem_req.waddr = ptr_reg;
        mem_req.wdata = store_val;
        unique case (state_reg)
            ST_RD_B: mem_req.raddr = wrap_inc(ipr, len_reg);
            ST_WR_A: mem_req.raddr = slot_a;
            ST_WR_B: mem_req.raddr = wrap_inc(ptr_reg, len_reg);
            default: mem_req.raddr = ipr;
        endcase
        if (state_reg == ST_CLEAR)
        begin
            mem_req.we    = 1'b1;
            mem_req.waddr = clr_reg;
            mem_req.wdata = '0;
        end
        else if (state_reg == ST_WR_STORE)
        begin
            mem_req.we = 1'b1;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_reg == ADDR_W'(DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_RD_A;
                end
            end
            ST_RD_A:     state_next = ST_RD_B;
            ST_RD_B:     state_next = ST_RD_DIFF;
            ST_RD_DIFF:  state_next = ST_RD_MUL;
            ST_RD_MUL:   state_next = ST_RD_SUM;
            ST_RD_SUM:   state_next = ST_WR_A;
            ST_WR_A:     state_next = ST_WR_B;
            ST_WR_B:     state_next = ST_WR_DIFF;
            ST_WR_DIFF:  state_next = ST_WR_MUL;
            ST_WR_MUL:   state_next = ST_WR_Y0;
            ST_WR_Y0:    state_next = ST_WR_SETUP;
            ST_WR_SETUP: state_next = ST_WR_TMUL;
            ST_WR_TMUL:  state_next = ST_WR_DIVGO;
            ST_WR_DIVGO: state_next = ST_WR_DIV;
            ST_WR_DIV:
            begin
                if (div_rsp.done)
                begin
                    state_next = ST_WR_STORE;
                end
            end
            ST_WR_STORE:
            begin
                state_next = (cnt_reg == SLOT_CNT_W'(1)) ? ST_DONE : ST_WR_TMUL;
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:     state_next = ST_CLEAR;
        endcase
        if (len_write)
        begin
            state_next = ST_CLEAR;
        end
    end

    // Handshake outputs
    always_comb
    begin
        in_ready   = (state_reg == ST_IDLE);
        out_valid  = out_valid_reg;
        sample_out = out_data_reg;
    end

    // Control state, configuration and heads
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            rate_reg      <= RATE_ONE;
            len_reg       <= LEN_W'(DEPTH);
            wpos_reg      <= '0;
            rpos_reg      <= POS_W'(DEPTH) << (FRAC_BITS - 1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
            begin
                clr_reg <= clr_reg + ADDR_W'(1);
            end

            // Heads advance when the result transfer is loaded
            if (out_load)
            begin
                wpos_reg <= advance(wpos_reg, reff, len_reg);
                rpos_reg <= advance(rpos_reg, reff, len_reg);
            end

            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_RATE:
                    begin
                        rate_reg <= cfg_data;
                    end
                    REG_LENGTH:
                    begin
                        len_reg  <= len_clamp;
                        wpos_reg <= '0;
                        rpos_reg <= {len_clamp, {(FRAC_BITS - 1){1'b0}}};
                        rate_reg <= RATE_ONE;
                        clr_reg  <= '0;
                    end
                    default:
                    begin
                        rate_reg <= rate_reg;
                    end
                endcase
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                sample_reg <= sample_in;
                x0_reg     <= x0_next;
            end
            ST_RD_B:
            begin
                a_reg <= rdata;
            end
            ST_RD_DIFF:
            begin
                diff_reg <= DIFF_W'(rdata) - DIFF_W'(a_reg);
            end
            ST_RD_MUL:
            begin
                prod_reg <= mul_p;
            end
            ST_RD_SUM:
            begin
                result_reg <= interp_sat;
            end
            ST_WR_A:
            begin
                ptr_reg <= slot_a;
                cnt_reg <= cnt_calc[SLOT_CNT_W-1:0];
            end
            ST_WR_B:
            begin
                a_reg <= rdata;
            end
            ST_WR_DIFF:
            begin
                diff_reg <= DIFF_W'(rdata) - DIFF_W'(a_reg);
            end
            ST_WR_MUL:
            begin
                prod_reg <= mul_p;
            end
            ST_WR_Y0:
            begin
                y0_reg <= interp_sat;
            end
            ST_WR_SETUP:
            begin
                diff_reg <= DIFF_W'(sample_reg) - DIFF_W'(y0_reg);
                t_reg    <= RATE_ONE - RATE_W'(fr0);
                ptr_reg  <= wrap_inc(ptr_reg, len_reg);
            end
            ST_WR_TMUL:
            begin
                prod_reg <= mul_p;
            end
            ST_WR_DIVGO:
            begin
                neg_reg <= n_val[DIVN_W];
            end
            ST_WR_STORE:
            begin
                ptr_reg <= wrap_inc(ptr_reg, len_reg);
                t_reg   <= t_reg + RATE_ONE;
                cnt_reg <= cnt_reg - SLOT_CNT_W'(1);
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    out_data_reg <= result_reg;
                end
            end
            default:
            begin
                neg_reg <= neg_reg;
            end
        endcase
    end

    // Checks
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("second item taken while one is in flight");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result transfer raised outside the finishing step");

    a_div_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == ST_WR_DIV))
        else $error("divider finished while the sequencer was not waiting");

    a_slot_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WR_STORE) |-> (cnt_reg != '0) && (cnt_reg <= SLOT_CNT_W'(5)))
        else $error("slot count out of range in the write loop");

endmodule

`default_nettype wire

// ===== sv/vrid_line.sv =====
// Sample line memory: one write port, one registered read port.
`default_nettype none

module vrid_line (
    input  wire logic                                clk,
    input  wire vrid_pkg::mem_req_t                  req,
    output logic signed [vrid_pkg::SAMPLE_W-1:0]     rdata
);
    import vrid_pkg::*;

    logic signed [SAMPLE_W-1:0] mem [DEPTH];
    logic signed [SAMPLE_W-1:0] rdata_reg;

    // Write when enabled; read every cycle
    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        rdata_reg <= mem[req.raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== sv/vrid_div.sv =====
// Restoring bit-serial divider, one quotient bit per cycle.
`default_nettype none

module vrid_div (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire vrid_pkg::div_req_t req,
    output vrid_pkg::div_rsp_t      rsp
);
    import vrid_pkg::*;

    logic              busy_reg;
    logic              busy_next;
    logic              done_reg;
    logic              done_next;
    logic [DIVC_W-1:0] cnt_reg;
    logic [DIVC_W-1:0] cnt_next;
    logic [DIVD_W-1:0] rem_reg;
    logic [DIVD_W-1:0] rem_next;
    logic [DIVN_W-1:0] quo_reg;
    logic [DIVN_W-1:0] quo_next;
    logic [DIVD_W-1:0] dvs_reg;
    logic [DIVD_W-1:0] dvs_next;

    logic [DIVD_W:0]   shifted;
    logic [DIVD_W:0]   trial;
    logic              fits;

    // One restoring step
    always_comb
    begin
        shifted = {rem_reg, quo_reg[DIVN_W-1]};
        trial   = shifted - {1'b0, dvs_reg};
        fits    = (shifted >= {1'b0, dvs_reg});
    end

    // Next values
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = DIVC_W'(DIVN_W);
            rem_next  = '0;
            quo_next  = req.dividend;
            dvs_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? trial[DIVD_W-1:0] : shifted[DIVD_W-1:0];
            quo_next = {quo_reg[DIVN_W-2:0], fits};
            cnt_next = cnt_reg - DIVC_W'(1);
            if (cnt_reg == DIVC_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Operands
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

`default_nettype wire
